>>> sv/snne_pkg.sv
// Shared constants and register codes for the sparse nearest-neighbor expander.
`default_nettype none
package snne_pkg;

  // Fixed field widths of the stream payload
  localparam int FIELD_W   = 16;
  localparam int VALUE_W   = 64;
  localparam int IN_DATA_W = 2 * FIELD_W + VALUE_W;
  localparam int OUT_DATA_W = 2 * FIELD_W + VALUE_W;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_ROWS = 2'd0,
    REG_SOURCE_COLS = 2'd1,
    REG_TARGET_ROWS = 2'd2,
    REG_TARGET_COLS = 2'd3
  } cfg_reg_t;

  // Quotient bits resolved per divider pipeline stage
  localparam int DIV_STEPS = 4;

endpackage
`default_nettype wire

>>> sv/snne_ceil_div.sv
// Pipelined restoring divider giving a saturated ceiling quotient.
`default_nettype none
module snne_ceil_div import snne_pkg::*; #(
  parameter int IB = 16
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*IB:0]   num,
  input  wire logic [IB:0]     den,
  output logic      [IB+1:0]   ceil_q
);

  localparam int QW  = IB + 1;
  localparam int NW  = 2 * IB + 1;
  localparam int NST = (QW + DIV_STEPS - 1) / DIV_STEPS;

  logic [IB:0]   rem_in [NST];
  logic [IB:0]   rem_nx [NST];
  logic [IB:0]   rem_q  [NST];
  logic [QW-1:0] lo_in  [NST];
  logic [QW-1:0] lo_nx  [NST];
  logic [QW-1:0] lo_q   [NST];
  logic [QW-1:0] quo_in [NST];
  logic [QW-1:0] quo_nx [NST];
  logic [QW-1:0] quo_q  [NST];
  logic          sat_in [NST];
  logic          sat_q  [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    // Feed the stage from the numerator or from the previous stage
    if (s == 0) begin : g_first
      assign rem_in[s] = {1'b0, num[NW-1:QW]};
      assign lo_in[s]  = num[QW-1:0];
      assign quo_in[s] = '0;
      assign sat_in[s] = ({1'b0, num[NW-1:QW]} >= den);
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign lo_in[s]  = lo_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign sat_in[s] = sat_q[s-1];
    end

    // Resolve a few quotient bits
    always_comb begin
      logic [IB:0]   r;
      logic [QW-1:0] lo;
      logic [QW-1:0] q;
      logic [IB+1:0] t;
      logic          qb;
      r  = rem_in[s];
      lo = lo_in[s];
      q  = quo_in[s];
      for (int j = 0; j < DIV_STEPS; j++) begin
        if (s * DIV_STEPS + j < QW) begin
          t  = {r, lo[QW-1]};
          qb = 1'b0;
          if (t >= {1'b0, den}) begin
            t  = t - {1'b0, den};
            qb = 1'b1;
          end
          r  = t[IB:0];
          lo = {lo[QW-2:0], 1'b0};
          q  = {q[QW-2:0], qb};
        end
      end
      rem_nx[s] = r;
      lo_nx[s]  = lo;
      quo_nx[s] = q;
    end

    // Hold on stall
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_nx[s];
        lo_q[s]  <= lo_nx[s];
        quo_q[s] <= quo_nx[s];
        sat_q[s] <= sat_in[s];
      end
    end
  end

  // Round up on a nonzero remainder, pin to all ones on overflow
  assign ceil_q = sat_q[NST-1] ? '1 :
                  ({1'b0, quo_q[NST-1]} + {{QW{1'b0}}, (rem_q[NST-1] != '0)});

endmodule
`default_nettype wire

>>> sv/snne_emit.sv
// Cell generator: walks an entry's rows and columns, one cell a cycle when ready.
`default_nettype none
module snne_emit import snne_pkg::*; #(
  parameter int IB = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load_valid,
  output logic                       load_ready,
  input  wire logic [IB-1:0]         row_first,
  input  wire logic [IB-1:0]         row_end,
  input  wire logic [IB-1:0]         col_first,
  input  wire logic [IB-1:0]         col_end,
  input  wire logic [VALUE_W-1:0]    value,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tlast
);

  logic               busy;
  logic [IB-1:0]      row_cur;
  logic [IB-1:0]      col_cur;
  logic [IB-1:0]      col_base;
  logic [IB-1:0]      row_stop;
  logic [IB-1:0]      col_stop;
  logic [VALUE_W-1:0] value_q;
  logic               last;

  assign last       = (row_cur == row_stop) && (col_cur == col_stop);
  assign load_ready = !busy || (m_tready && last);

  // Load a new span or, per taken cell, step across a row's columns, then rows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load_ready) begin
      busy <= load_valid;
      if (load_valid) begin
        row_cur  <= row_first;
        col_cur  <= col_first;
        col_base <= col_first;
        row_stop <= row_end;
        col_stop <= col_end;
        value_q  <= value;
      end
    end else if (m_tready) begin
      if (col_cur == col_stop) begin
        col_cur <= col_base;
        row_cur <= row_cur + 1'b1;
      end else begin
        col_cur <= col_cur + 1'b1;
      end
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = last;
  assign m_tdata  = {value_q, FIELD_W'(col_cur), FIELD_W'(row_cur)};

endmodule
`default_nettype wire

>>> sv/sparse_nearest_neighbor_expand_top.sv
// Top level of the sparse nearest-neighbor expander.
//
//  port group  dir  payload
//  s_*         in   tdata: entry_row, entry_col, entry_value
//  m_*         out  tdata: out_row, out_col, out_value; tlast: out_last
//  cfg_*       in   index 0..3: source_rows, source_cols, target_rows, target_cols
//
//  An entry passes a multiply stage, (IB+4)/4 divider stages and a clamp stage,
//  then the cell generator emits its cells at one per cycle while m_tready is high.
//  An entry yields rows*cols cells (up to MAX_SCALE squared);
//  entries with a zero value (either sign) or an empty span yield no cells.
//  Reset sets all four size registers to 1 and empties the pipeline.
//  Output stalls freeze a full clamp stage and all before it; no drops, no repeats.
`default_nettype none
module sparse_nearest_neighbor_expand_top import snne_pkg::*; #(
  parameter int INDEX_BITS = 16,
  parameter int MAX_SCALE  = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [IN_DATA_W-1:0]   s_tdata,  // entry_row, entry_col, entry_value
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [OUT_DATA_W-1:0]       m_tdata,  // out_row, out_col, out_value
  output logic                        m_tlast,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int IB  = INDEX_BITS;
  localparam int QW  = IB + 1;
  localparam int NW  = 2 * IB + 1;
  localparam int NST = (QW + DIV_STEPS - 1) / DIV_STEPS;

  logic [IB-1:0] source_rows;
  logic [IB-1:0] source_cols;
  logic [IB-1:0] target_rows;
  logic [IB-1:0] target_cols;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_rows <= IB'(1);
      source_cols <= IB'(1);
      target_rows <= IB'(1);
      target_cols <= IB'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_ROWS: source_rows <= IB'(cfg_data);
        REG_SOURCE_COLS: source_cols <= IB'(cfg_data);
        REG_TARGET_ROWS: target_rows <= IB'(cfg_data);
        REG_TARGET_COLS: target_cols <= IB'(cfg_data);
        default: ;
      endcase
    end
  end

  logic          en;
  logic          emit_ready;
  logic          cv_q;

  assign en       = !cv_q || emit_ready;
  assign s_tready = en;

  // Denominators 2*max(S,1)
  logic [IB:0] den_row;
  logic [IB:0] den_col;
  assign den_row = (source_rows == '0) ? (IB+1)'(2) : {source_rows, 1'b0};
  assign den_col = (source_cols == '0) ? (IB+1)'(2) : {source_cols, 1'b0};

  // Input fields
  logic [IB-1:0]      in_row;
  logic [IB-1:0]      in_col;
  logic [VALUE_W-1:0] in_value;
  assign in_row   = IB'(s_tdata[FIELD_W-1:0]);
  assign in_col   = IB'(s_tdata[2*FIELD_W-1:FIELD_W]);
  assign in_value = s_tdata[IN_DATA_W-1:2*FIELD_W];

  // Span factors 2i-1 (zero for the first index) and 2i+1
  logic [IB:0] fa_row, fb_row, fa_col, fb_col;
  assign fa_row = (in_row == '0) ? '0 : ({in_row, 1'b0} - 1'b1);
  assign fb_row = {in_row, 1'b1};
  assign fa_col = (in_col == '0) ? '0 : ({in_col, 1'b0} - 1'b1);
  assign fb_col = {in_col, 1'b1};

  // Multiply stage
  logic               p1_valid;
  logic               p1_nz;
  logic [VALUE_W-1:0] p1_value;
  logic [NW-1:0]      na_row, nb_row, na_col, nb_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_nz    <= (in_value[VALUE_W-2:0] != '0);
      p1_value <= in_value;
      na_row   <= NW'(fa_row) * NW'(target_rows);
      nb_row   <= NW'(fb_row) * NW'(target_rows);
      na_col   <= NW'(fa_col) * NW'(target_cols);
      nb_col   <= NW'(fb_col) * NW'(target_cols);
    end
  end

  // Four ceiling dividers in lockstep
  logic [IB+1:0] ca_row, cb_row, ca_col, cb_col;

  snne_ceil_div #(.IB(IB)) u_div_ra (
    .clk(clk), .en(en), .num(na_row), .den(den_row), .ceil_q(ca_row));
  snne_ceil_div #(.IB(IB)) u_div_rb (
    .clk(clk), .en(en), .num(nb_row), .den(den_row), .ceil_q(cb_row));
  snne_ceil_div #(.IB(IB)) u_div_ca (
    .clk(clk), .en(en), .num(na_col), .den(den_col), .ceil_q(ca_col));
  snne_ceil_div #(.IB(IB)) u_div_cb (
    .clk(clk), .en(en), .num(nb_col), .den(den_col), .ceil_q(cb_col));

  // Side line alongside the dividers
  logic               line_valid [NST];
  logic               line_nz    [NST];
  logic [VALUE_W-1:0] line_value [NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) line_valid[k] <= 1'b0;
    end else if (en) begin
      line_valid[0] <= p1_valid;
      for (int k = 1; k < NST; k++) line_valid[k] <= line_valid[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      line_nz[0]    <= p1_nz;
      line_value[0] <= p1_value;
      for (int k = 1; k < NST; k++) begin
        line_nz[k]    <= line_nz[k-1];
        line_value[k] <= line_value[k-1];
      end
    end
  end

  // Clamp to [0,N], widen an empty span, cap at MAX_SCALE
  function automatic logic [2*IB:0] span_fn(input logic [IB+1:0] ca,
                                             input logic [IB+1:0] cb,
                                             input logic [IB-1:0] n);
    logic [IB:0] a;
    logic [IB:0] b;
    logic [IB:0] e;
    logic        ok;
    a = (ca > (IB+2)'(n)) ? {1'b0, n} : ca[IB:0];
    b = (cb > (IB+2)'(n)) ? {1'b0, n} : cb[IB:0];
    if (b <= a) b = ((a + 1'b1) > {1'b0, n}) ? {1'b0, n} : (a + 1'b1);
    if (b > a + (IB+1)'(MAX_SCALE)) b = a + (IB+1)'(MAX_SCALE);
    ok = (b > a);
    e  = b - 1'b1;
    return {ok, a[IB-1:0], e[IB-1:0]};
  endfunction

  logic [2*IB:0] span_row;
  logic [2*IB:0] span_col;
  assign span_row = span_fn(ca_row, cb_row, target_rows);
  assign span_col = span_fn(ca_col, cb_col, target_cols);

  // Clamp stage
  logic [IB-1:0]      rf_q, re_q, cf_q, ce_q;
  logic [VALUE_W-1:0] cval_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_q <= 1'b0;
    end else if (en) begin
      cv_q <= line_valid[NST-1] && line_nz[NST-1] && span_row[2*IB] && span_col[2*IB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rf_q   <= span_row[2*IB-1:IB];
      re_q   <= span_row[IB-1:0];
      cf_q   <= span_col[2*IB-1:IB];
      ce_q   <= span_col[IB-1:0];
      cval_q <= line_value[NST-1];
    end
  end

  snne_emit #(.IB(IB)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (cv_q),
    .load_ready (emit_ready),
    .row_first  (rf_q),
    .row_end    (re_q),
    .col_first  (cf_q),
    .col_end    (ce_q),
    .value      (cval_q),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // A stalled clamp stage keeps its span
  a_clamp_hold: assert property (@(posedge clk) disable iff (rst)
    (cv_q && !en) |=> (cv_q && $stable(rf_q) && $stable(cf_q) && $stable(re_q)))
    else $error("clamp stage changed while stalled");

  // A cell taken that is not the last leaves more cells to send
  a_more_cells: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("entry ended before its last cell");

  // Span start never passes its end
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    cv_q |-> (rf_q <= re_q && cf_q <= ce_q))
    else $error("span start beyond span end");

  // Input is taken only when the pipeline moves
  a_ready_move: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> p1_valid)
    else $error("accepted request not captured");

endmodule
`default_nettype wire

>>> test/sparse_nearest_neighbor_expand_top_tb.sv
// Self-checking testbench for the sparse nearest-neighbor expander.
`timescale 1ns / 100ps
module sparse_nearest_neighbor_expand_top_tb;
  import snne_pkg::*;

  localparam int MAX_SCALE = 8;
  localparam int SETTLE = 40;

  typedef struct {
    logic [15:0] row;
    logic [15:0] col;
    logic [63:0] value;
    logic        last;
  } cell_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   m_tlast;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow copy of the size registers
  logic [15:0] src_rows, src_cols, dst_rows, dst_cols;

  cell_t cell_q[$];
  int    errors;
  int    send_idle;
  int    recv_stall;

  sparse_nearest_neighbor_expand_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Compute the target span of one axis
  function automatic void axis_span(input longint unsigned idx, input longint unsigned src,
                                    input longint unsigned dst, output longint unsigned a,
                                    output longint unsigned b);
    longint unsigned den;
    longint unsigned num;
    if (src == 0) src = 1;
    den = 2 * src;
    if (idx == 0) a = 0;
    else begin
      num = (2 * idx - 1) * dst;
      a = num / den + ((num % den) != 0 ? 1 : 0);
    end
    num = (2 * idx + 1) * dst;
    b = num / den + ((num % den) != 0 ? 1 : 0);
    if (a > dst) a = dst;
    if (b > dst) b = dst;
    if (b <= a) b = (a + 1 > dst) ? dst : a + 1;
    if (b > a + MAX_SCALE) b = a + MAX_SCALE;
  endfunction

  // Queue every cell one entry expands to
  task automatic predict_cells(input logic [15:0] row, input logic [15:0] col,
                               input logic [63:0] value);
    longint unsigned ra, rb, ca, cb;
    cell_t c;
    if (value[62:0] == 63'd0) return;
    axis_span(64'(row), 64'(src_rows), 64'(dst_rows), ra, rb);
    axis_span(64'(col), 64'(src_cols), 64'(dst_cols), ca, cb);
    if (rb <= ra || cb <= ca) return;
    for (longint unsigned r = ra; r < rb; r++)
      for (longint unsigned k = ca; k < cb; k++) begin
        c.row = r[15:0];
        c.col = k[15:0];
        c.value = value;
        c.last = (r + 1 == rb && k + 1 == cb);
        cell_q.push_back(c);
      end
  endtask

  // Send one entry request with random idle gaps
  task automatic send_entry(input logic [15:0] row, input logic [15:0] col,
                            input logic [63:0] value);
    while ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {value, col, row};
    do @(posedge clk); while (!s_tready);
    predict_cells(row, col, value);
  endtask

  // Drop valid and wait until every expected cell has come out
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (cell_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_SOURCE_ROWS: src_rows = val;
      REG_SOURCE_COLS: src_cols = val;
      REG_TARGET_ROWS: dst_rows = val;
      default:         dst_cols = val;
    endcase
  endtask

  task automatic set_sizes(input logic [15:0] sr, input logic [15:0] sc,
                           input logic [15:0] tr, input logic [15:0] tc);
    drain();
    cfg_write(REG_SOURCE_ROWS, sr);
    cfg_write(REG_SOURCE_COLS, sc);
    cfg_write(REG_TARGET_ROWS, tr);
    cfg_write(REG_TARGET_COLS, tc);
    cfg_we <= 1'b0;
  endtask

  // Check each output cell against the oldest expectation
  always @(posedge clk) begin
    cell_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (cell_q.size() == 0) begin
        $display("%0t: unexpected cell row=%0d col=%0d", $time, m_tdata[15:0],
                 m_tdata[31:16]);
        errors++;
      end else begin
        e = cell_q.pop_front();
        if (m_tdata[15:0] !== e.row) begin
          $display("%0t: row expected %0d actual %0d", $time, e.row, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[31:16] !== e.col) begin
          $display("%0t: col expected %0d actual %0d", $time, e.col, m_tdata[31:16]);
          errors++;
        end
        if (m_tdata[95:32] !== e.value) begin
          $display("%0t: value expected %h actual %h", $time, e.value, m_tdata[95:32]);
          errors++;
        end
        if (m_tlast !== e.last) begin
          $display("%0t: last expected %0b actual %0b", $time, e.last, m_tlast);
          errors++;
        end
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  function automatic logic [15:0] pick_index(input logic [15:0] size);
    if ($urandom_range(0, 9) == 0 || size == 0) return 16'($urandom_range(0, 65534));
    return 16'($urandom_range(0, size - 1));
  endfunction

  function automatic logic [63:0] pick_value;
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 15))
      0: v = 64'd0;
      1: v = 64'h8000_0000_0000_0000;
      default: ;
    endcase
    return v;
  endfunction

  // Extremes of the fields, zeros, NaN and the special sizes
  task automatic test_directed;
    send_entry(16'd0, 16'd0, 64'h3FF0_0000_0000_0000);
    send_entry(16'd0, 16'd0, 64'd0);
    send_entry(16'd0, 16'd0, 64'h8000_0000_0000_0000);
    send_entry(16'd0, 16'd0, 64'h7FF8_0000_0000_0001);
    send_entry(16'd65534, 16'd65534, 64'hFFFF_FFFF_FFFF_FFFF);
    set_sizes(16'd4, 16'd4, 16'd16, 16'd16);
    send_entry(16'd0, 16'd3, 64'h0000_0000_0000_0001);
    send_entry(16'd3, 16'd0, 64'hAAAA_5555_AAAA_5555);
    send_entry(16'd4, 16'd1, 64'h5555_AAAA_5555_AAAA);
    send_entry(16'd2, 16'd65534, 64'h1);
    set_sizes(16'd1, 16'd1, 16'd65535, 16'd65535);
    send_entry(16'd0, 16'd0, 64'hC000_0000_0000_0000);
    set_sizes(16'd0, 16'd0, 16'd3, 16'd5);
    send_entry(16'd0, 16'd0, 64'h2);
    send_entry(16'd1, 16'd0, 64'h3);
    set_sizes(16'd3, 16'd3, 16'd0, 16'd0);
    send_entry(16'd1, 16'd1, 64'h4);
    set_sizes(16'd65535, 16'd65535, 16'd1, 16'd1);
    send_entry(16'd32767, 16'd32767, 64'h5);
    send_entry(16'd65534, 16'd0, 64'h6);
    set_sizes(16'd7, 16'd5, 16'd3, 16'd23);
    for (int i = 0; i < 7; i++) send_entry(i[15:0], 16'(i % 5), 64'h7 + i);
  endtask

  // Random entries under a few random size settings
  task automatic test_random(input int items);
    for (int i = 0; i < items; i++) begin
      if (i % 50 == 0) begin
        if ($urandom_range(0, 7) == 0)
          set_sizes(16'($urandom_range(30000, 65535)), 16'($urandom_range(1, 3)),
                    16'($urandom_range(1, 65535)), 16'($urandom_range(1, 24)));
        else
          set_sizes(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                    16'($urandom_range(1, 200)), 16'($urandom_range(1, 200)));
      end
      send_entry(pick_index(src_rows), pick_index(src_cols), pick_value());
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SOURCE_ROWS;
    cfg_data = '0;
    errors = 0;
    send_idle = 32;
    recv_stall = 56;
    src_rows = 16'd1;
    src_cols = 16'd1;
    dst_rows = 16'd1;
    dst_cols = 16'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(150);
    send_idle = 56;
    recv_stall = 32;
    test_random(150);
    send_idle = 0;
    recv_stall = 0;
    test_random(150);
    drain();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
